### rtl/rdef_pkg.sv
// Shared types, register codes and constants of the RMS dB envelope follower.
`default_nettype none

package rdef_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLED          = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGHPASS_ON      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGHPASS_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGHPASS_POLE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSITIVITY      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ATTACK_COEF      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_RELEASE_COEF     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEAN_SQUARE_COEF = 3'd7;

    localparam logic [16:0]        UNITY_Q16         = 17'd65536;
    localparam logic [39:0]        MS_MAX            = 40'hFF_FFFF_FFFF;
    localparam logic signed [19:0] DB_PER_OCTAVE_Q16 = 20'sd394566;
    localparam logic [24:0]        MAX_DROP_Q15      = 25'd786432;
    localparam logic [28:0]        LIN_ONE           = 29'h1000_0000;
    localparam int                 QUEUE_DEPTH       = 2;

    typedef struct packed {
        logic        enabled;
        logic        highpass_on;
        logic [16:0] highpass_gain;
        logic [16:0] highpass_pole;
        logic [23:0] sensitivity;
        logic [16:0] attack_coef;
        logic [16:0] release_coef;
        logic [16:0] mean_square_coef;
    } cfg_t;

    typedef enum logic {
        ITEM_ZERO,
        ITEM_RUN
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic               last;
        logic               two;
        logic signed [23:0] x0;
        logic signed [23:0] x1;
    } item_t;

    typedef struct packed {
        logic        start;
        logic [28:0] value;
    } log_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [23:0] db;
    } log_rsp_t;

    function automatic logic [16:0] sat_coef(input logic [16:0] c);
        return (c > UNITY_Q16) ? UNITY_Q16 : c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -35'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

`default_nettype wire

### rtl/rdef_frame_if.sv
// Input frame channel: valid/ready handshake with the frame payload.
`default_nettype none

interface rdef_frame_if #(parameter int SAMPLE_BITS = 24);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_first;
    logic signed [SAMPLE_BITS-1:0] sample_second;
    logic [1:0]                    channel_count;
    logic                          end_of_block;

    modport source(output valid, sample_first, sample_second, channel_count, end_of_block,
                   input ready);
    modport sink(input valid, sample_first, sample_second, channel_count, end_of_block,
                 output ready);
endinterface

`default_nettype wire

### rtl/rdef_result_if.sv
// Result channel: valid/ready handshake with the linear envelope.
`default_nettype none

interface rdef_result_if;
    logic        valid;
    logic        ready;
    logic [16:0] envelope;

    modport source(output valid, envelope, input ready);
    modport sink(input valid, envelope, output ready);
endinterface

`default_nettype wire

### rtl/rdef_front.sv
// Front end: takes frames, drops idle ones and turns the rest into work items.
`default_nettype none

module rdef_front
    import rdef_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int SAMPLE_BITS = 24
)
(
    rdef_frame_if.sink frame,
    input  logic       cfg_enabled,
    output logic       push_valid,
    input  logic       push_ready,
    output item_t      push_item
);

    localparam int UP = (SAMPLE_BITS < 24) ? 24 - SAMPLE_BITS : 0;
    localparam int DN = (SAMPLE_BITS > 24) ? SAMPLE_BITS - 24 : 0;

    function automatic logic signed [23:0] to_q23(input logic signed [SAMPLE_BITS-1:0] s);
        logic signed [32:0] w;
        w = 33'(s);
        w = (w <<< UP) >>> DN;
        return w[23:0];
    endfunction

    // A disabled frame that does not close a block causes nothing and is dropped.
    assign frame.ready = push_ready;
    assign push_valid  = frame.valid && (cfg_enabled || frame.end_of_block);

    always_comb
    begin
        push_item.kind = cfg_enabled ? ITEM_RUN : ITEM_ZERO;
        push_item.last = frame.end_of_block;
        push_item.two  = (CHANNELS > 1) && frame.channel_count[1];
        push_item.x0   = to_q23(frame.sample_first);
        push_item.x1   = to_q23(frame.sample_second);
    end

endmodule

`default_nettype wire

### rtl/rdef_queue.sv
// Short item queue between the front end and the back end.
`default_nettype none

module rdef_queue
    import rdef_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop,
    output item_t pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

### rtl/rdef_log.sv
// Iterative dB converter: normalize, sixteen mantissa squarings, scale to Q9.15.
`default_nettype none

module rdef_log
    import rdef_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  log_req_t req,
    output log_rsp_t rsp
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_NORM = 3'd1;
    localparam logic [2:0] L_SQ   = 3'd2;
    localparam logic [2:0] L_MUL  = 3'd3;
    localparam logic [2:0] L_FIN  = 3'd4;

    logic [2:0]         state_reg;
    logic               done_reg;
    logic [30:0]        m_reg;
    logic [4:0]         b_reg;
    logic [15:0]        frac_reg;
    logic [3:0]         cnt_reg;
    logic signed [42:0] prod_reg;
    logic signed [23:0] db_reg;

    logic [61:0]        sq;
    logic [31:0]        sq_top;
    logic [5:0]         octave;
    logic signed [21:0] log2_q16;
    logic signed [42:0] m_db;
    logic signed [42:0] fin_sum;

    assign sq       = m_reg * m_reg;
    assign sq_top   = sq[61:30];
    assign octave   = {1'b0, b_reg} - 6'd28;
    assign log2_q16 = {octave, frac_reg};
    assign m_db     = log2_q16 * DB_PER_OCTAVE_Q16;
    assign fin_sum  = prod_reg + 43'sd65536;

    assign rsp.busy = (state_reg != L_IDLE);
    assign rsp.done = done_reg;
    assign rsp.db   = db_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE:
                    if (req.start)
                        state_reg <= L_NORM;
                L_NORM:
                    if (m_reg[30])
                        state_reg <= L_SQ;
                L_SQ:
                    if (cnt_reg == 4'd15)
                        state_reg <= L_MUL;
                L_MUL:
                    state_reg <= L_FIN;
                L_FIN:
                begin
                    state_reg <= L_IDLE;
                    done_reg  <= 1'b1;
                end
                default:
                    state_reg <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            L_IDLE:
            begin
                m_reg    <= {2'b00, req.value};
                b_reg    <= 5'd30;
                cnt_reg  <= '0;
                frac_reg <= '0;
            end
            L_NORM:
            begin
                // Coarse steps of eight while the top byte is empty, then single bits.
                if (!m_reg[30] && m_reg[30:23] == 8'd0)
                begin
                    m_reg <= {m_reg[22:0], 8'd0};
                    b_reg <= b_reg - 5'd8;
                end
                else if (!m_reg[30])
                begin
                    m_reg <= {m_reg[29:0], 1'b0};
                    b_reg <= b_reg - 5'd1;
                end
            end
            L_SQ:
            begin
                m_reg    <= sq_top[31] ? sq_top[31:1] : sq_top[30:0];
                frac_reg <= {frac_reg[14:0], sq_top[31]};
                cnt_reg  <= cnt_reg + 4'd1;
            end
            L_MUL:
                prod_reg <= m_db;
            L_FIN:
                db_reg <= fin_sum[40:17];
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/rdef_back.sv
// Back end: high-pass, mean square, root, dB smoother and linear readout sequencer.
`default_nettype none

module rdef_back
    import rdef_pkg::*;
#(
    parameter int FLOOR_DB = -100
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            pop_valid,
    input  item_t           pop_item,
    output logic            pop,
    output log_req_t        log_req,
    input  log_rsp_t        log_rsp,
    rdef_result_if.source   result
);

    localparam logic signed [23:0] FLOOR_Q15 = 24'(FLOOR_DB * 32768);

    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_CH        = 5'd1;
    localparam logic [4:0] ST_HP_Y      = 5'd2;
    localparam logic [4:0] ST_HP_PY     = 5'd3;
    localparam logic [4:0] ST_HP_MEM    = 5'd4;
    localparam logic [4:0] ST_SQ        = 5'd5;
    localparam logic [4:0] ST_ACC       = 5'd6;
    localparam logic [4:0] ST_MEAN      = 5'd7;
    localparam logic [4:0] ST_INT_MUL   = 5'd8;
    localparam logic [4:0] ST_INT_ADD   = 5'd9;
    localparam logic [4:0] ST_SQRT      = 5'd10;
    localparam logic [4:0] ST_SENS_MUL  = 5'd11;
    localparam logic [4:0] ST_SENS_LIM  = 5'd12;
    localparam logic [4:0] ST_TGT       = 5'd13;
    localparam logic [4:0] ST_DROP      = 5'd14;
    localparam logic [4:0] ST_COEF_MUL  = 5'd15;
    localparam logic [4:0] ST_COEF_LIM  = 5'd16;
    localparam logic [4:0] ST_STEP_MUL  = 5'd17;
    localparam logic [4:0] ST_STEP_ADD  = 5'd18;
    localparam logic [4:0] ST_SRCH      = 5'd19;
    localparam logic [4:0] ST_SRCH_WAIT = 5'd20;
    localparam logic [4:0] ST_OUT       = 5'd21;

    // Control and state
    logic [4:0]         state_reg;
    logic               out_valid_reg;
    logic signed [31:0] mem_reg [2];
    logic               fc_two_reg;
    logic [39:0]        ms_reg;
    logic signed [23:0] env_reg;

    // Working registers
    item_t              item_reg;
    logic               ch_reg;
    logic signed [25:0] gx_reg;
    logic signed [31:0] y_reg;
    logic signed [65:0] prod_reg;
    logic [64:0]        sum_reg;
    logic signed [40:0] diff_reg;
    logic [59:0]        rad_reg;
    logic [29:0]        root_reg;
    logic [32:0]        rem_reg;
    logic [4:0]         cnt_reg;
    logic signed [23:0] tgt_reg;
    logic               rise_reg;
    logic               neg_reg;
    logic [24:0]        absd_reg;
    logic [16:0]        coef_reg;
    logic [16:0]        lo_reg;
    logic [16:0]        hi_reg;
    logic [16:0]        mid_reg;
    logic [16:0]        res_reg;
    logic [16:0]        envelope_reg;

    // Datapath
    logic signed [23:0] x_sel;
    logic signed [17:0] g_s;
    logic signed [16:0] p_s;
    logic signed [17:0] cms_s;
    logic signed [41:0] m_gx;
    logic signed [41:0] gx_round;
    logic signed [25:0] gx_w;
    logic signed [34:0] y_sum;
    logic signed [31:0] y_new;
    logic signed [48:0] m_py;
    logic signed [48:0] py_round;
    logic signed [32:0] py_w;
    logic signed [31:0] mem_new;
    logic [31:0]        y_abs;
    logic [63:0]        m_sq;
    logic [64:0]        half;
    logic [54:0]        mean_full;
    logic [39:0]        mean40;
    logic signed [58:0] m_int;
    logic signed [43:0] ms_sum;
    logic [39:0]        ms_new;
    logic [34:0]        rem_t;
    logic [34:0]        trial;
    logic [34:0]        rem_sub;
    logic               root_ge;
    logic [53:0]        m_sens;
    logic [37:0]        lin;
    logic [28:0]        lin_c;
    logic signed [24:0] d_w;
    logic [24:0]        drop_c;
    logic [18:0]        accel;
    logic [35:0]        m_acc;
    logic [19:0]        coef_raw;
    logic [41:0]        m_step;
    logic [42:0]        step_sum;
    logic [26:0]        step;
    logic signed [27:0] env_wide;
    logic [17:0]        mid_sum;
    logic [16:0]        mid_w;
    logic               srch_go;
    logic               out_free;

    assign x_sel    = ch_reg ? item_reg.x1 : item_reg.x0;
    assign g_s      = signed'({1'b0, sat_coef(cfg.highpass_gain)});
    assign p_s      = signed'(cfg.highpass_pole);
    assign cms_s    = signed'({1'b0, sat_coef(cfg.mean_square_coef)});

    assign m_gx     = g_s * x_sel;
    assign gx_round = signed'(prod_reg[41:0]) + 42'sd32768;
    assign gx_w     = gx_round[41:16];
    assign y_sum    = 35'(gx_w) + 35'(mem_reg[ch_reg]);
    assign y_new    = sat32(y_sum);
    assign m_py     = p_s * y_reg;
    assign py_round = signed'(prod_reg[48:0]) + 49'sd32768;
    assign py_w     = py_round[48:16];
    assign mem_new  = sat32(-35'(gx_reg) - 35'(py_w));

    assign y_abs    = y_reg[31] ? unsigned'(-y_reg) : unsigned'(y_reg);
    assign m_sq     = y_abs * y_abs;

    assign half      = item_reg.two ? (sum_reg >> 1) : sum_reg;
    assign mean_full = half[64:10];
    assign mean40    = (mean_full[54:40] != '0) ? MS_MAX : mean_full[39:0];

    assign m_int  = cms_s * diff_reg;
    assign ms_sum = signed'({4'b0000, ms_reg}) + signed'({prod_reg[58], prod_reg[58:16]});
    always_comb
    begin
        if (ms_sum < 0)
            ms_new = '0;
        else if (ms_sum > signed'({4'b0000, MS_MAX}))
            ms_new = MS_MAX;
        else
            ms_new = ms_sum[39:0];
    end

    // One root bit per cycle from the top two radicand bits.
    assign rem_t   = {rem_reg, rad_reg[59:58]};
    assign trial   = {3'b000, root_reg, 2'b01};
    assign root_ge = (rem_t >= trial);
    assign rem_sub = rem_t - trial;

    assign m_sens = root_reg * cfg.sensitivity;
    assign lin    = prod_reg[53:16];
    assign lin_c  = (lin > 38'(LIN_ONE)) ? LIN_ONE : lin[28:0];

    assign d_w      = 25'(tgt_reg) - 25'(env_reg);
    assign drop_c   = (absd_reg > MAX_DROP_Q15) ? MAX_DROP_Q15 : absd_reg;
    assign accel    = 19'(UNITY_Q16) + 19'(drop_c >> 1);
    assign m_acc    = sat_coef(cfg.release_coef) * accel;
    assign coef_raw = prod_reg[35:16];
    assign m_step   = coef_reg * absd_reg;
    assign step_sum = {1'b0, prod_reg[41:0]} + 43'd65535;
    assign step     = step_sum[42:16];
    assign env_wide = neg_reg ? (28'(env_reg) - signed'({1'b0, step}))
                              : (28'(env_reg) + signed'({1'b0, step}));

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg} + 18'd1;
    assign mid_w    = mid_sum[17:1];
    assign srch_go  = (env_reg > FLOOR_Q15) && (lo_reg < hi_reg);
    assign out_free = !out_valid_reg || result.ready;

    assign pop = (state_reg == ST_IDLE) && pop_valid;

    always_comb
    begin
        log_req.start = 1'b0;
        log_req.value = {mid_w, 12'd0};
        if (state_reg == ST_SENS_LIM)
        begin
            log_req.start = (lin_c != '0);
            log_req.value = lin_c;
        end
        else if (state_reg == ST_SRCH)
            log_req.start = srch_go;
    end

    assign result.valid    = out_valid_reg;
    assign result.envelope = envelope_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            mem_reg[0]    <= '0;
            mem_reg[1]    <= '0;
            fc_two_reg    <= 1'b1;
            ms_reg        <= '0;
            env_reg       <= FLOOR_Q15;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (pop_valid)
                    begin
                        if (pop_item.kind == ITEM_ZERO)
                            state_reg <= ST_OUT;
                        else
                        begin
                            state_reg <= ST_CH;
                            // With the high-pass on, a new channel count invalidates the filter memories.
                            if (cfg.highpass_on && pop_item.two != fc_two_reg)
                            begin
                                mem_reg[0] <= '0;
                                mem_reg[1] <= '0;
                                fc_two_reg <= pop_item.two;
                            end
                        end
                    end
                ST_CH:        state_reg <= cfg.highpass_on ? ST_HP_Y : ST_SQ;
                ST_HP_Y:      state_reg <= ST_HP_PY;
                ST_HP_PY:     state_reg <= ST_HP_MEM;
                ST_HP_MEM:
                begin
                    mem_reg[ch_reg] <= mem_new;
                    state_reg       <= ST_SQ;
                end
                ST_SQ:        state_reg <= ST_ACC;
                ST_ACC:       state_reg <= (item_reg.two && !ch_reg) ? ST_CH : ST_MEAN;
                ST_MEAN:      state_reg <= ST_INT_MUL;
                ST_INT_MUL:   state_reg <= ST_INT_ADD;
                ST_INT_ADD:
                begin
                    ms_reg    <= ms_new;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                    if (cnt_reg == '0)
                        state_reg <= ST_SENS_MUL;
                ST_SENS_MUL:  state_reg <= ST_SENS_LIM;
                ST_SENS_LIM:  state_reg <= (lin_c != '0) ? ST_TGT : ST_DROP;
                ST_TGT:
                    if (log_rsp.done)
                        state_reg <= ST_DROP;
                ST_DROP:      state_reg <= ST_COEF_MUL;
                ST_COEF_MUL:  state_reg <= rise_reg ? ST_STEP_MUL : ST_COEF_LIM;
                ST_COEF_LIM:  state_reg <= ST_STEP_MUL;
                ST_STEP_MUL:  state_reg <= ST_STEP_ADD;
                ST_STEP_ADD:
                begin
                    env_reg   <= env_wide[23:0];
                    state_reg <= item_reg.last ? ST_SRCH : ST_IDLE;
                end
                ST_SRCH:      state_reg <= srch_go ? ST_SRCH_WAIT : ST_OUT;
                ST_SRCH_WAIT:
                    if (log_rsp.done)
                        state_reg <= ST_SRCH;
                ST_OUT:
                    if (out_free)
                        state_reg <= ST_IDLE;
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                item_reg <= pop_item;
                ch_reg   <= 1'b0;
                sum_reg  <= '0;
                res_reg  <= '0;
            end
            ST_CH:
            begin
                prod_reg <= 66'(m_gx);
                y_reg    <= 32'(x_sel);
            end
            ST_HP_Y:
            begin
                gx_reg <= gx_w;
                y_reg  <= y_new;
            end
            ST_HP_PY:     prod_reg <= 66'(m_py);
            ST_SQ:        prod_reg <= signed'({2'b00, m_sq});
            ST_ACC:
            begin
                sum_reg <= sum_reg + {1'b0, prod_reg[63:0]};
                ch_reg  <= 1'b1;
            end
            ST_MEAN:      diff_reg <= signed'({1'b0, mean40}) - signed'({1'b0, ms_reg});
            ST_INT_MUL:   prod_reg <= 66'(m_int);
            ST_INT_ADD:
            begin
                rad_reg  <= {ms_new, 20'd0};
                root_reg <= '0;
                rem_reg  <= '0;
                cnt_reg  <= 5'd29;
            end
            ST_SQRT:
            begin
                rad_reg <= {rad_reg[57:0], 2'b00};
                cnt_reg <= cnt_reg - 5'd1;
                if (root_ge)
                begin
                    rem_reg  <= rem_sub[32:0];
                    root_reg <= {root_reg[28:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_t[32:0];
                    root_reg <= {root_reg[28:0], 1'b0};
                end
            end
            ST_SENS_MUL:  prod_reg <= signed'({12'd0, m_sens});
            ST_SENS_LIM:  tgt_reg  <= FLOOR_Q15;
            ST_TGT:
                if (log_rsp.done)
                    tgt_reg <= (log_rsp.db < FLOOR_Q15) ? FLOOR_Q15 : log_rsp.db;
            ST_DROP:
            begin
                rise_reg <= (tgt_reg > env_reg);
                neg_reg  <= d_w[24];
                absd_reg <= d_w[24] ? unsigned'(-d_w) : unsigned'(d_w);
            end
            ST_COEF_MUL:
            begin
                coef_reg <= sat_coef(cfg.attack_coef);
                prod_reg <= signed'({30'd0, m_acc});
            end
            ST_COEF_LIM:
                coef_reg <= (coef_raw > 20'(UNITY_Q16)) ? UNITY_Q16 : coef_raw[16:0];
            ST_STEP_MUL:  prod_reg <= signed'({24'd0, m_step});
            ST_STEP_ADD:
            begin
                lo_reg <= '0;
                hi_reg <= UNITY_Q16;
            end
            ST_SRCH:
            begin
                mid_reg <= mid_w;
                // The envelope at or below the floor reads as zero.
                res_reg <= (env_reg > FLOOR_Q15) ? lo_reg : '0;
            end
            ST_SRCH_WAIT:
                if (log_rsp.done)
                begin
                    if (log_rsp.db <= env_reg)
                        lo_reg <= mid_reg;
                    else
                        hi_reg <= mid_reg - 17'd1;
                end
            ST_OUT:
                if (out_free)
                    envelope_reg <= res_reg;
            default:
            begin
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.envelope <= UNITY_Q16)
        else $error("envelope above unity");

    a_env_floor: assert property (@(posedge clk) disable iff (!rst_n)
        env_reg >= FLOOR_Q15)
        else $error("smoothed level below floor");

    a_log_idle: assert property (@(posedge clk) disable iff (!rst_n)
        log_req.start |-> !log_rsp.busy)
        else $error("dB converter started while busy");
`endif

endmodule

`default_nettype wire

### rtl/rms_db_envelope_follower_unit.sv
// Top level of the RMS dB envelope follower: configuration registers and wiring.
//
//   port     dir  role    payload
//   frame    in   sink    sample_first, sample_second, channel_count, end_of_block
//   result   out  source  envelope
//   cfg_*    in   write   cfg_index selects the register, cfg_data carries the value
//
// A frame without end_of_block passes the bit-serial square root and the dB converter
// in the back end. A frame with end_of_block adds a search of up to 17 steps over the
// shared dB converter. A disabled end-of-block frame gives a zero.
// Reset clears the filter memories, the integrator and the smoother to the floor.
// A two-entry queue and the output register let frames transfer while a result waits.
`default_nettype none

module rms_db_envelope_follower_unit
    import rdef_pkg::*;
#(
    parameter int CHANNELS    = 2,
    parameter int FLOOR_DB    = -100,
    parameter int SAMPLE_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    rdef_frame_if.sink             frame,
    rdef_result_if.source          result
);

    cfg_t     cfg_reg;
    logic     push_valid;
    logic     push_ready;
    item_t    push_item;
    logic     pop_valid;
    logic     pop;
    item_t    pop_item;
    log_req_t log_req;
    log_rsp_t log_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled          <= 1'b0;
            cfg_reg.highpass_on      <= 1'b0;
            cfg_reg.highpass_gain    <= UNITY_Q16;
            cfg_reg.highpass_pole    <= '0;
            cfg_reg.sensitivity      <= 24'(UNITY_Q16);
            cfg_reg.attack_coef      <= UNITY_Q16;
            cfg_reg.release_coef     <= UNITY_Q16;
            cfg_reg.mean_square_coef <= 17'd656;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLED:          cfg_reg.enabled          <= cfg_data[0];
                CFG_HIGHPASS_ON:      cfg_reg.highpass_on      <= cfg_data[0];
                CFG_HIGHPASS_GAIN:    cfg_reg.highpass_gain    <= cfg_data[16:0];
                CFG_HIGHPASS_POLE:    cfg_reg.highpass_pole    <= cfg_data[16:0];
                CFG_SENSITIVITY:      cfg_reg.sensitivity      <= cfg_data;
                CFG_ATTACK_COEF:      cfg_reg.attack_coef      <= cfg_data[16:0];
                CFG_RELEASE_COEF:     cfg_reg.release_coef     <= cfg_data[16:0];
                CFG_MEAN_SQUARE_COEF: cfg_reg.mean_square_coef <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

    rdef_front #(
        .CHANNELS    (CHANNELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .frame       (frame),
        .cfg_enabled (cfg_reg.enabled),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    rdef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_item   (pop_item)
    );

    rdef_log u_log (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (log_req),
        .rsp   (log_rsp)
    );

    rdef_back #(
        .FLOOR_DB (FLOOR_DB)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop       (pop),
        .log_req   (log_req),
        .log_rsp   (log_rsp),
        .result    (result)
    );

endmodule

`default_nettype wire

### dv/tb_rms_db_envelope_follower_unit.sv
// Self-checking testbench for the RMS dB envelope follower: directed and random frames, predicted envelopes.
`default_nettype none

module tb_rms_db_envelope_follower_unit;
    import rdef_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FLOOR_DB       = -100;
    localparam int  SETTLE_CYCLES  = 700;
    localparam int  HOLD_CYCLES    = 3000;
    localparam int  RANDOM_PHASES  = 10;
    localparam int  PHASE_FRAMES   = 190;

    typedef struct {
        logic [23:0] first;
        logic [23:0] second;
        logic [1:0]  count;
        logic        eob;
    } frame_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    rdef_frame_if #(.SAMPLE_BITS(24)) frame_ch ();
    rdef_result_if                     result_ch ();

    rms_db_envelope_follower_unit #(
        .CHANNELS   (2),
        .FLOOR_DB   (FLOOR_DB),
        .SAMPLE_BITS(24)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .frame    (frame_ch),
        .result   (result_ch)
    );

    // Register shadow and state of the envelope predictor.
    cfg_t    shadow;
    longint  hp_mem [2];
    int      hp_channels;
    longint unsigned ms_acc;
    longint  env_db;

    frame_t      pending_frames[$];
    logic [16:0] expected_envelopes[$];

    int  mismatches;
    bit  frame_took;
    bit  result_took;
    int  send_gap;
    int  recv_stall;
    bit  quiet_send;
    bit  quiet_recv;
    bit  hold_kick;
    int  hold_left;

    initial begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic longint sat_32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        else if (v < -64'sd2147483648)
            return -64'sd2147483648;
        else
            return v;
    endfunction

    function automatic longint clamp_coef(input logic [16:0] c);
        return (c > 17'd65536) ? 64'sd65536 : longint'(c);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // Decibels in Q9.15 of a Q1.28 value, before the floor is applied.
    function automatic longint decibels(input longint unsigned v);
        int              b;
        longint unsigned m;
        longint          frac;
        longint          l;
        b = 0;
        frac = 0;
        while (b < 63 && (v >> (b + 1)) != 0)
            b++;
        if (b > 30)
            b = 30;
        m = v << (30 - b);
        for (int k = 0; k < 16; k++)
        begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31))
            begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        l = longint'(b - 28) * 65536 + frac;
        return (l * 394566 + 65536) >>> 17;
    endfunction

    function automatic longint highpass(input int ch, input longint x);
        longint g;
        longint p;
        longint gx;
        longint y;
        longint py;
        g = clamp_coef(shadow.highpass_gain);
        p = longint'(signed'(shadow.highpass_pole));
        gx = (g * x + 32768) >>> 16;
        y = sat_32(gx + hp_mem[ch]);
        py = (p * y + 32768) >>> 16;
        hp_mem[ch] = sat_32(-gx - py);
        return y;
    endfunction

    function automatic logic [16:0] linear_envelope();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (env_db <= longint'(FLOOR_DB) * 32768)
            return 17'd0;
        lo = 0;
        hi = 65536;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            if (decibels(mid << 12) <= env_db)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[16:0];
    endfunction

    // Advances the follower by one frame; returns 1 with the envelope when one is reported.
    function automatic bit follow_frame(input frame_t f, output logic [16:0] env);
        int              n;
        longint unsigned sum;
        longint unsigned mean;
        longint unsigned sq;
        longint unsigned lin;
        longint          x;
        longint          y;
        longint          diff;
        longint          target;
        longint          coef;
        longint          drop;
        longint          fl;
        env = 17'd0;
        fl = longint'(FLOOR_DB) * 32768;
        if (!shadow.enabled)
            return f.eob;
        n = (f.count == 2'd0) ? 1 : (f.count == 2'd3) ? 2 : int'(f.count);
        if (shadow.highpass_on && n != hp_channels)
        begin
            hp_mem[0] = 0;
            hp_mem[1] = 0;
            hp_channels = n;
        end
        sum = 0;
        for (int ch = 0; ch < n; ch++)
        begin
            x = (ch == 0) ? longint'(signed'(f.first)) : longint'(signed'(f.second));
            y = shadow.highpass_on ? highpass(ch, x) : x;
            sq = longint'(y < 0 ? -y : y);
            sum = sum + sq * sq;
        end
        mean = (sum / n) >> 10;
        if (mean > 64'hFF_FFFF_FFFF)
            mean = 64'hFF_FFFF_FFFF;
        diff = longint'(mean) - longint'(ms_acc);
        diff = longint'(ms_acc) + ((clamp_coef(shadow.mean_square_coef) * diff) >>> 16);
        if (diff < 0)
            diff = 0;
        if (diff > 64'shFF_FFFF_FFFF)
            diff = 64'sh FF_FFFF_FFFF;
        ms_acc = diff;
        lin = (int_sqrt(ms_acc << 20) * longint'(shadow.sensitivity)) >> 16;
        if (lin > (64'd1 << 28))
            lin = 64'd1 << 28;
        target = fl;
        if (lin != 0)
        begin
            target = decibels(lin);
            if (target < fl)
                target = fl;
        end
        if (target > env_db)
            coef = clamp_coef(shadow.attack_coef);
        else
        begin
            drop = env_db - target;
            if (drop > 24 * 32768)
                drop = 24 * 32768;
            coef = (clamp_coef(shadow.release_coef) * (65536 + (6 * drop) / 12)) >> 16;
            if (coef > 65536)
                coef = 65536;
        end
        diff = target - env_db;
        if (diff >= 0)
            env_db = env_db + ((coef * diff + 65535) >> 16);
        else
            env_db = env_db - ((coef * (-diff) + 65535) >> 16);
        if (!f.eob)
            return 1'b0;
        env = linear_envelope();
        return 1'b1;
    endfunction

    // Frame side: acceptance, prediction and result checking at the rising edge.
    always @(posedge clk)
    begin
        logic [16:0] env;
        logic [16:0] want;
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                frame_took = 1'b1;
                if (follow_frame(pending_frames[0], env))
                    expected_envelopes.push_back(env);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                result_took = 1'b1;
                if (expected_envelopes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected envelope %0d with nothing pending",
                                 result_ch.envelope);
                end
                else
                begin
                    want = expected_envelopes.pop_front();
                    if (result_ch.envelope !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("envelope mismatch: expected %0d, got %0d",
                                     want, result_ch.envelope);
                    end
                end
            end
        end
    end

    // Frame driver: one transfer per queued frame, with a random gap after each unless sending is quiet.
    always @(negedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = frame_ch.valid;
            if (frame_took)
            begin
                frame_took = 1'b0;
                void'(pending_frames.pop_front());
                send_gap = quiet_send ? 0 : $urandom_range(0, 15);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_frames.size() != 0)
                begin
                    next_valid = 1'b1;
                    frame_ch.sample_first  <= pending_frames[0].first;
                    frame_ch.sample_second <= pending_frames[0].second;
                    frame_ch.channel_count <= pending_frames[0].count;
                    frame_ch.end_of_block  <= pending_frames[0].eob;
                end
            end
            frame_ch.valid <= next_valid;
        end
    end

    // Long receiver hold-off, counted down on its own.
    always @(negedge clk)
    begin
        if (hold_kick)
        begin
            hold_kick = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        else if (hold_left > 0)
            hold_left--;
    end

    // Result side ready: a random stall after each transfer unless receiving is quiet, and the long hold-off.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_took)
            begin
                result_took = 1'b0;
                recv_stall = quiet_recv ? 0 : $urandom_range(0, 15);
            end
            if (hold_left > 0)
                result_ch.ready <= 1'b0;
            else if (recv_stall > 0)
            begin
                recv_stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [23:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        case (idx)
            CFG_ENABLED:          shadow.enabled          = value[0];
            CFG_HIGHPASS_ON:      shadow.highpass_on      = value[0];
            CFG_HIGHPASS_GAIN:    shadow.highpass_gain    = value[16:0];
            CFG_HIGHPASS_POLE:    shadow.highpass_pole    = value[16:0];
            CFG_SENSITIVITY:      shadow.sensitivity      = value;
            CFG_ATTACK_COEF:      shadow.attack_coef      = value[16:0];
            CFG_RELEASE_COEF:     shadow.release_coef     = value[16:0];
            CFG_MEAN_SQUARE_COEF: shadow.mean_square_coef = value[16:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        while (pending_frames.size() != 0 || frame_ch.valid || expected_envelopes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_frame(input logic [23:0] a, input logic [23:0] b,
                               input logic [1:0] cnt, input logic eob);
        frame_t f;
        f.first  = a;
        f.second = b;
        f.count  = cnt;
        f.eob    = eob;
        pending_frames.push_back(f);
    endtask

    function automatic logic [23:0] random_sample();
        case ($urandom_range(0, 5))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'($urandom() >> (8 + $urandom_range(0, 23)));
            3: return 24'(-($urandom() >> (8 + $urandom_range(0, 23))));
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [16:0] random_coef();
        case ($urandom_range(0, 5))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'h1FFFF;
            3: return 17'($urandom_range(0, 2000));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    initial begin
        logic [1:0] cnt;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ENABLED;
        cfg_data = '0;
        frame_ch.valid = 1'b0;
        frame_ch.sample_first = '0;
        frame_ch.sample_second = '0;
        frame_ch.channel_count = 2'd1;
        frame_ch.end_of_block = 1'b0;
        result_ch.ready = 1'b0;
        mismatches = 0;
        frame_took = 1'b0;
        result_took = 1'b0;
        send_gap = 0;
        recv_stall = 0;
        quiet_send = 1'b0;
        quiet_recv = 1'b0;
        hold_kick = 1'b0;
        hold_left = 0;
        shadow.enabled = 1'b0;
        shadow.highpass_on = 1'b0;
        shadow.highpass_gain = 17'd65536;
        shadow.highpass_pole = 17'd0;
        shadow.sensitivity = 24'd65536;
        shadow.attack_coef = 17'd65536;
        shadow.release_coef = 17'd65536;
        shadow.mean_square_coef = 17'd656;
        hp_mem[0] = 0;
        hp_mem[1] = 0;
        hp_channels = 2;
        ms_acc = 0;
        env_db = longint'(FLOOR_DB) * 32768;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Disabled block: end of block reports zero, other frames vanish.
        queue_frame(24'h7FFFFF, 24'h800000, 2'd2, 1'b0);
        queue_frame(24'h7FFFFF, 24'h800000, 2'd2, 1'b1);
        drain();

        write_reg(CFG_ENABLED, 24'd1);
        write_reg(CFG_HIGHPASS_ON, 24'd1);
        write_reg(CFG_HIGHPASS_GAIN, 24'd32768);
        write_reg(CFG_HIGHPASS_POLE, 24'h10000);
        write_reg(CFG_SENSITIVITY, 24'd65536);
        write_reg(CFG_ATTACK_COEF, 24'd65536);
        write_reg(CFG_RELEASE_COEF, 24'd65536);
        write_reg(CFG_MEAN_SQUARE_COEF, 24'd65536);
        // Full scale, silence, odd channel counts and a channel change that clears the filter.
        queue_frame(24'h7FFFFF, 24'h7FFFFF, 2'd2, 1'b1);
        queue_frame(24'h800000, 24'h800000, 2'd2, 1'b1);
        queue_frame(24'h000000, 24'h000000, 2'd2, 1'b1);
        queue_frame(24'h7FFFFF, 24'h123456, 2'd1, 1'b1);
        queue_frame(24'h800000, 24'h7FFFFF, 2'd3, 1'b0);
        queue_frame(24'h400000, 24'hC00000, 2'd0, 1'b1);
        queue_frame(24'h000001, 24'hFFFFFF, 2'd2, 1'b1);
        queue_frame(24'h000000, 24'h000000, 2'd1, 1'b1);
        queue_frame(24'h7FFFFF, 24'h800000, 2'd2, 1'b0);
        queue_frame(24'h7FFFFF, 24'h800000, 2'd2, 1'b1);
        drain();
        write_reg(CFG_HIGHPASS_ON, 24'd0);
        write_reg(CFG_SENSITIVITY, 24'hFFFFFF);
        write_reg(CFG_ATTACK_COEF, 24'd0);
        write_reg(CFG_RELEASE_COEF, 24'h1FFFF);
        write_reg(CFG_MEAN_SQUARE_COEF, 24'h1FFFF);
        queue_frame(24'h000100, 24'h000000, 2'd1, 1'b1);
        queue_frame(24'h000000, 24'h000000, 2'd2, 1'b1);
        queue_frame(24'h7FFFFF, 24'h7FFFFF, 2'd2, 1'b1);
        queue_frame(24'h000000, 24'h000000, 2'd2, 1'b1);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            write_reg(CFG_ENABLED, (ph == 4) ? 24'd0 : 24'd1);
            write_reg(CFG_HIGHPASS_ON, 24'($urandom_range(0, 1)));
            write_reg(CFG_HIGHPASS_GAIN, 24'((ph == 1) ? 17'h1FFFF : (ph == 2) ? 17'd32768 :
                      17'($urandom_range(32768, 65536))));
            write_reg(CFG_HIGHPASS_POLE, 24'((ph == 1) ? 17'h0FFFF : (ph == 2) ? 17'h10000 :
                      17'(-$urandom_range(0, 65536))));
            write_reg(CFG_SENSITIVITY, (ph == 1) ? 24'hFFFFFF : (ph == 2) ? 24'd0 :
                      24'($urandom_range(16384, 1048576)));
            write_reg(CFG_ATTACK_COEF, 24'(random_coef()));
            write_reg(CFG_RELEASE_COEF, 24'(random_coef()));
            write_reg(CFG_MEAN_SQUARE_COEF, 24'(random_coef()));
            quiet_send = (ph % 3 == 1);
            quiet_recv = (ph % 4 == 2);
            if (ph == 3)
                hold_kick = 1'b1;
            for (int i = 0; i < PHASE_FRAMES; i++)
            begin
                cnt = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) :
                      2'($urandom_range(1, 2));
                queue_frame(random_sample(), random_sample(), cnt,
                            $urandom_range(0, 3) == 0);
            end
            drain();
        end

        if (mismatches == 0)
            $display("rms_db_envelope_follower_unit verification clean");
        else
            $display("rms_db_envelope_follower_unit verification failed");
        $finish;
    end

    initial begin
        #60ms;
        $display("rms_db_envelope_follower_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
rtl/rdef_pkg.sv
rtl/rdef_frame_if.sv
rtl/rdef_result_if.sv
rtl/rdef_front.sv
rtl/rdef_queue.sv
rtl/rdef_log.sv
rtl/rdef_back.sv
rtl/rms_db_envelope_follower_unit.sv
dv/tb_rms_db_envelope_follower_unit.sv
